[design/ispcs_pkg.sv]
// Shared types, codes and frame constants for the serial programming sequencer.
// Used by the front, queue, back and top-level files; depends on nothing.
package ispcs_pkg;

  // Word kinds on the input channel (tuser)
  localparam logic [1:0] KIND_REQ   = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Host operations
  localparam logic [2:0] OP_READ_FLASH   = 3'd0;
  localparam logic [2:0] OP_READ_EEPROM  = 3'd1;
  localparam logic [2:0] OP_WRITE_EEPROM = 3'd2;
  localparam logic [2:0] OP_LOAD_FLASH   = 3'd3;
  localparam logic [2:0] OP_COMMIT_PAGE  = 3'd4;
  localparam logic [2:0] OP_BUSY         = 3'd5;

  // Result kinds (out tuser bit 0)
  localparam logic OUT_TX   = 1'b0;
  localparam logic OUT_DONE = 1'b1;

  // First bytes of the serial frames
  localparam logic [7:0] CMD_READ_FLASH   = 8'h20;
  localparam logic [7:0] CMD_READ_EEPROM  = 8'hA0;
  localparam logic [7:0] CMD_WRITE_EEPROM = 8'hC0;
  localparam logic [7:0] CMD_LOAD_FLASH   = 8'h40;
  localparam logic [7:0] CMD_COMMIT_PAGE  = 8'h4C;
  localparam logic [7:0] CMD_BUSY         = 8'hF0;
  localparam logic [7:0] ERASED_BYTE      = 8'hFF;

  // Configuration register indexes
  localparam logic [2:0] REG_EEPROM_FULL_WAIT  = 3'd0;
  localparam logic [2:0] REG_EEPROM_MAX_CHECKS = 3'd1;
  localparam logic [2:0] REG_EEPROM_POLL_WAIT  = 3'd2;
  localparam logic [2:0] REG_FLASH_FULL_WAIT   = 3'd3;
  localparam logic [2:0] REG_FLASH_MAX_CHECKS  = 3'd4;
  localparam logic [2:0] REG_FLASH_POLL_WAIT   = 3'd5;
  localparam logic [2:0] REG_PAGE_POLL_TRIES   = 3'd6;
  localparam logic [2:0] REG_PAGE_POLL_WAIT    = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_REPLY = 2'd1,
    PH_WAIT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] eeprom_full_wait;
    logic [7:0]  eeprom_max_checks;
    logic [15:0] eeprom_poll_wait;
    logic [15:0] flash_full_wait;
    logic [7:0]  flash_max_checks;
    logic [15:0] flash_poll_wait;
    logic [7:0]  page_poll_tries;
    logic [15:0] page_poll_wait;
  } cfg_t;

  // One queued job: a four-byte frame or a completion
  typedef struct packed {
    logic            is_frame;
    logic [3:0][7:0] bytes;
    logic [7:0]      read_value;
    logic            busy;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic job_t make_frame(logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3);
    job_t j;
    j = '0;
    j.is_frame = 1'b1;
    j.bytes[0] = b0;
    j.bytes[1] = b1;
    j.bytes[2] = b2;
    j.bytes[3] = b3;
    return j;
  endfunction

  function automatic job_t make_done(logic [7:0] rv, logic busy);
    job_t j;
    j = '0;
    j.read_value = rv;
    j.busy = busy;
    return j;
  endfunction

  // Flash read of byte address a: low/high byte picked by bit 0
  function automatic job_t flash_read_frame(logic [15:0] a);
    logic [15:0] w;
    w = a >> 1;
    return make_frame(CMD_READ_FLASH | {4'b0, a[0], 3'b0}, w[15:8], w[7:0], 8'h00);
  endfunction

endpackage

[design/ispcs_front.sv]
// Front part: accepts input words, runs the operation state and queues jobs.
// Depends on ispcs_pkg.
module ispcs_front #(
  parameter int ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          kind,
  input  logic [2:0]          op,
  input  logic [15:0]         byte_address,
  input  logic [7:0]          write_value,
  input  logic                poll_enable,
  input  logic [7:0]          reply_byte,
  input  ispcs_pkg::cfg_t     cfg,
  output logic                push,
  output ispcs_pkg::job_t     job
);

  ispcs_pkg::phase_t      phase_r, phase_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [ADDR_BITS-1:0]   addr_r, addr_nxt;
  logic [7:0]             val_r, val_nxt;
  logic                   hpoll_r, hpoll_nxt;
  logic [7:0]             tries_r, tries_nxt;
  logic [15:0]            wait_r, wait_nxt;
  logic                   polling_r, polling_nxt;

  logic [15:0] in_a16, held_a16, in_w, wait_ticks, wait_dec;
  logic        do_wait, do_after, do_poll, done, done_busy;
  logic [7:0]  done_rv;

  assign in_a16   = 16'(byte_address[ADDR_BITS-1:0]);
  assign held_a16 = 16'(addr_r);
  assign in_w     = in_a16 >> 1;

  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    val_nxt     = val_r;
    hpoll_nxt   = hpoll_r;
    tries_nxt   = tries_r;
    wait_nxt    = wait_r;
    polling_nxt = polling_r;
    push        = 1'b0;
    job         = '0;
    do_wait     = 1'b0;
    do_after    = 1'b0;
    do_poll     = 1'b0;
    done        = 1'b0;
    done_rv     = 8'h00;
    done_busy   = 1'b0;
    wait_ticks  = 16'h0000;
    wait_dec    = 16'h0000;

    if (accept) begin
      case (kind)
        ispcs_pkg::KIND_REQ: begin
          if (phase_r == ispcs_pkg::PH_IDLE && op <= ispcs_pkg::OP_BUSY) begin
            op_nxt      = op;
            addr_nxt    = byte_address[ADDR_BITS-1:0];
            val_nxt     = write_value;
            hpoll_nxt   = poll_enable;
            polling_nxt = 1'b0;
            phase_nxt   = ispcs_pkg::PH_REPLY;
            push        = 1'b1;
            case (op)
              ispcs_pkg::OP_READ_FLASH:
                job = ispcs_pkg::flash_read_frame(in_a16);
              ispcs_pkg::OP_READ_EEPROM:
                job = ispcs_pkg::make_frame(ispcs_pkg::CMD_READ_EEPROM,
                                            in_a16[15:8], in_a16[7:0], 8'h00);
              ispcs_pkg::OP_WRITE_EEPROM:
                job = ispcs_pkg::make_frame(ispcs_pkg::CMD_WRITE_EEPROM,
                                            in_a16[15:8], in_a16[7:0], write_value);
              ispcs_pkg::OP_LOAD_FLASH:
                job = ispcs_pkg::make_frame(
                        ispcs_pkg::CMD_LOAD_FLASH | {4'b0, in_a16[0], 3'b0},
                        in_w[15:8], in_w[7:0], write_value);
              ispcs_pkg::OP_COMMIT_PAGE:
                job = ispcs_pkg::make_frame(ispcs_pkg::CMD_COMMIT_PAGE,
                                            in_w[15:8], in_w[7:0], 8'h00);
              default:
                job = ispcs_pkg::make_frame(ispcs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00);
            endcase
          end
        end
        ispcs_pkg::KIND_REPLY: begin
          if (phase_r == ispcs_pkg::PH_REPLY) begin
            case (op_r)
              ispcs_pkg::OP_READ_FLASH, ispcs_pkg::OP_READ_EEPROM: begin
                done    = 1'b1;
                done_rv = reply_byte;
              end
              ispcs_pkg::OP_BUSY: begin
                done      = 1'b1;
                done_busy = reply_byte[0];
              end
              ispcs_pkg::OP_WRITE_EEPROM: begin
                if (polling_r) begin
                  if (reply_byte == val_r) done = 1'b1;
                  else begin
                    do_wait    = 1'b1;
                    wait_ticks = cfg.eeprom_poll_wait;
                  end
                end else if (val_r == ispcs_pkg::ERASED_BYTE) begin
                  do_wait    = 1'b1;
                  wait_ticks = cfg.eeprom_full_wait;
                end else begin
                  tries_nxt   = cfg.eeprom_max_checks;
                  polling_nxt = 1'b1;
                  do_poll     = 1'b1;
                end
              end
              ispcs_pkg::OP_LOAD_FLASH: begin
                if (polling_r) begin
                  if (reply_byte != ispcs_pkg::ERASED_BYTE) done = 1'b1;
                  else begin
                    do_wait    = 1'b1;
                    wait_ticks = cfg.flash_poll_wait;
                  end
                end else if (!hpoll_r) begin
                  done = 1'b1;
                end else if (val_r == ispcs_pkg::ERASED_BYTE) begin
                  do_wait    = 1'b1;
                  wait_ticks = cfg.flash_full_wait;
                end else begin
                  tries_nxt   = cfg.flash_max_checks;
                  polling_nxt = 1'b1;
                  do_poll     = 1'b1;
                end
              end
              ispcs_pkg::OP_COMMIT_PAGE: begin
                if (polling_r) begin
                  if (reply_byte != ispcs_pkg::ERASED_BYTE) done = 1'b1;
                  else begin
                    do_wait    = 1'b1;
                    wait_ticks = cfg.page_poll_wait;
                  end
                end else begin
                  tries_nxt   = cfg.page_poll_tries;
                  polling_nxt = 1'b1;
                  do_poll     = 1'b1;
                end
              end
              default: done = 1'b1;
            endcase
          end
        end
        ispcs_pkg::KIND_TICK: begin
          if (phase_r == ispcs_pkg::PH_WAIT) begin
            wait_dec = wait_r - 16'(wait_r != 16'h0000);
            wait_nxt = wait_dec;
            if (wait_dec == 16'h0000) do_after = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Start a wait; a zero count falls straight through to what follows it
    if (do_wait) begin
      wait_nxt = wait_ticks;
      if (wait_ticks == 16'h0000) do_after = 1'b1;
      else phase_nxt = ispcs_pkg::PH_WAIT;
    end

    if (do_after) begin
      if (polling_nxt) do_poll = 1'b1;
      else done = 1'b1;
    end

    // Next readback, or finish when the tries are used up
    if (do_poll) begin
      if (tries_nxt == 8'h00) begin
        done = 1'b1;
      end else begin
        tries_nxt   = tries_nxt - 8'd1;
        polling_nxt = 1'b1;
        phase_nxt   = ispcs_pkg::PH_REPLY;
        push        = 1'b1;
        if (op_r == ispcs_pkg::OP_WRITE_EEPROM)
          job = ispcs_pkg::make_frame(ispcs_pkg::CMD_READ_EEPROM,
                                      held_a16[15:8], held_a16[7:0], 8'h00);
        else
          job = ispcs_pkg::flash_read_frame(held_a16);
      end
    end

    if (done) begin
      push        = 1'b1;
      job         = ispcs_pkg::make_done(done_rv, done_busy);
      phase_nxt   = ispcs_pkg::PH_IDLE;
      polling_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ispcs_pkg::PH_IDLE;
      op_r      <= 3'd0;
      addr_r    <= '0;
      val_r     <= 8'h00;
      hpoll_r   <= 1'b0;
      tries_r   <= 8'h00;
      wait_r    <= 16'h0000;
      polling_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      op_r      <= op_nxt;
      addr_r    <= addr_nxt;
      val_r     <= val_nxt;
      hpoll_r   <= hpoll_nxt;
      tries_r   <= tries_nxt;
      wait_r    <= wait_nxt;
      polling_r <= polling_nxt;
    end
  end

endmodule

[design/ispcs_queue.sv]
// Job queue between front and back: a small circular buffer of jobs.
// Depends on ispcs_pkg.
module ispcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ispcs_pkg::job_t      push_job,
  input  logic                 pop,
  output ispcs_pkg::job_t      head,
  output ispcs_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ispcs_pkg::job_t      slot_r [DEPTH];
  logic [PW-1:0]        wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head         = slot_r[rd_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/ispcs_back.sv]
// Back part: expands queued jobs into result words behind an output register.
// Depends on ispcs_pkg.
module ispcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ispcs_pkg::job_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output logic [7:0]      tx_byte,
  output logic            frame_end,
  output logic [7:0]      read_value,
  output logic            busy_bit,
  output logic            last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       kind_r, kind_nxt, fend_r, fend_nxt, busy_r, busy_nxt, last_r, last_nxt;
  logic [7:0] tx_r, tx_nxt, rv_r, rv_nxt;
  logic       load;

  assign load = head_valid && (!valid_r || out_ready);

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    kind_nxt  = kind_r;
    fend_nxt  = fend_r;
    busy_nxt  = busy_r;
    last_nxt  = last_r;
    tx_nxt    = tx_r;
    rv_nxt    = rv_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.is_frame) begin
        kind_nxt = ispcs_pkg::OUT_TX;
        tx_nxt   = head.bytes[idx_r];
        fend_nxt = (idx_r == 2'd3);
        last_nxt = (idx_r == 2'd3);
        rv_nxt   = 8'h00;
        busy_nxt = 1'b0;
        pop      = (idx_r == 2'd3);
        idx_nxt  = idx_r + 2'd1;
      end else begin
        kind_nxt = ispcs_pkg::OUT_DONE;
        tx_nxt   = 8'h00;
        fend_nxt = 1'b0;
        last_nxt = 1'b1;
        rv_nxt   = head.read_value;
        busy_nxt = head.busy;
        pop      = 1'b1;
        idx_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    kind_r <= kind_nxt;
    fend_r <= fend_nxt;
    busy_r <= busy_nxt;
    last_r <= last_nxt;
    tx_r   <= tx_nxt;
    rv_r   <= rv_nxt;
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign tx_byte    = tx_r;
  assign frame_end  = fend_r;
  assign read_value = rv_r;
  assign busy_bit   = busy_r;
  assign last       = last_r;

endmodule

[design/isp_programming_command_sequencer_unit.sv]
// The first result word passes through the job queue and then the output register to out_tvalid.
// Throughput: one input word per cycle while the job queue has room; the output side
// delivers one result word per cycle while out_tready is high, four words for a frame job.
// An input word that causes no job costs nothing downstream.
// Reset (rst_n low, synchronous): phase idle, counters, queue pointers and output valid
// cleared, configuration registers back to their defaults.
module isp_programming_command_sequencer_unit #(
  parameter int ADDR_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[2:0], byte_address[18:3], write_value[26:19],
                                  // poll_enable[27], reply_byte[35:28], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // tx_byte[7:0], read_value[15:8], busy_bit[16], zero fill
  output logic [1:0]  out_tuser,  // out_kind[0], frame_end[1]
  output logic        out_tlast,  // last result word caused by one input word
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ispcs_pkg::cfg_t      cfg_r;
  ispcs_pkg::job_t      push_job, head_job;
  ispcs_pkg::q_status_t q_stat;
  logic                 push, pop, accept;
  logic                 o_kind, o_fend, o_busy;
  logic [7:0]           o_tx, o_rv;

  // Configuration registers: taken on any edge with the write enable high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eeprom_full_wait  <= 16'd1000;
      cfg_r.eeprom_max_checks <= 8'd10;
      cfg_r.eeprom_poll_wait  <= 16'd100;
      cfg_r.flash_full_wait   <= 16'd1000;
      cfg_r.flash_max_checks  <= 8'd10;
      cfg_r.flash_poll_wait   <= 16'd100;
      cfg_r.page_poll_tries   <= 8'd10;
      cfg_r.page_poll_wait    <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        ispcs_pkg::REG_EEPROM_FULL_WAIT:  cfg_r.eeprom_full_wait  <= cfg_wdata;
        ispcs_pkg::REG_EEPROM_MAX_CHECKS: cfg_r.eeprom_max_checks <= cfg_wdata[7:0];
        ispcs_pkg::REG_EEPROM_POLL_WAIT:  cfg_r.eeprom_poll_wait  <= cfg_wdata;
        ispcs_pkg::REG_FLASH_FULL_WAIT:   cfg_r.flash_full_wait   <= cfg_wdata;
        ispcs_pkg::REG_FLASH_MAX_CHECKS:  cfg_r.flash_max_checks  <= cfg_wdata[7:0];
        ispcs_pkg::REG_FLASH_POLL_WAIT:   cfg_r.flash_poll_wait   <= cfg_wdata;
        ispcs_pkg::REG_PAGE_POLL_TRIES:   cfg_r.page_poll_tries   <= cfg_wdata[7:0];
        ispcs_pkg::REG_PAGE_POLL_WAIT:    cfg_r.page_poll_wait    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take a word whenever the queue can hold the job it may cause
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  ispcs_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .kind         (in_tuser),
    .op           (in_tdata[2:0]),
    .byte_address (in_tdata[18:3]),
    .write_value  (in_tdata[26:19]),
    .poll_enable  (in_tdata[27]),
    .reply_byte   (in_tdata[35:28]),
    .cfg          (cfg_r),
    .push         (push),
    .job          (push_job)
  );

  ispcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .status   (q_stat)
  );

  // Drain jobs into words; the output register holds a word until taken
  ispcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_job),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .tx_byte    (o_tx),
    .frame_end  (o_fend),
    .read_value (o_rv),
    .busy_bit   (o_busy),
    .last       (out_tlast)
  );

  assign out_tdata = {7'b0, o_busy, o_rv, o_tx};
  assign out_tuser = {o_fend, o_kind};

`ifndef SYNTH
  // The front never queues a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // A pop only happens when the back loads a word from a present job
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty ##1 out_tvalid)
    else $error("job dropped without a word");

  // A completion word carries no serial byte and closes its run
  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tdata[7:0] == 8'h00 && !out_tuser[1]))
    else $error("malformed completion word");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the serial programming command sequencer: requests, target
// replies and ticks are streamed in and every result word is checked against a model.
// Depends on design/ispcs_pkg.sv and design/isp_programming_command_sequencer_unit.sv.
module testbench;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;   // margin kept after the last expected word is checked

  // One result word as the checker sees it
  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [7:0] read_value;
    logic       busy_bit;
    logic       tlast;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // op[2:0], byte_address[18:3], write_value[26:19],
                                 // poll_enable[27], reply_byte[35:28], zero fill
  logic [1:0]  in_tuser = '0;    // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // tx_byte[7:0], read_value[15:8], busy_bit[16], zero fill
  logic [1:0]  out_tuser;        // out_kind[0], frame_end[1]
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  isp_programming_command_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model: own copy of the settings and the operation state
  // ---------------------------------------------------------------------------
  ispcs_pkg::cfg_t   settings;
  ispcs_pkg::phase_t seq_phase;
  logic [2:0]        cur_op;
  logic [15:0]       held_addr;
  logic [7:0]        held_val;
  logic              held_poll;
  logic [7:0]        tries_left;
  logic [15:0]       wait_left;
  logic              readback;
  result_t           expected_words[$];

  // Bench control and bookkeeping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  result_t oldest;

  task automatic emit(input logic k, input logic [7:0] tx, input logic fe,
                      input logic [7:0] rv, input logic bz, input logic lst);
    result_t r;
    r.kind       = k;
    r.tx_byte    = tx;
    r.frame_end  = fe;
    r.read_value = rv;
    r.busy_bit   = bz;
    r.tlast      = lst;
    expected_words.push_back(r);
  endtask

  // Four serial bytes; the last one carries frame_end and tlast, then await the reply
  task automatic emit_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    emit(ispcs_pkg::OUT_TX, b0, 1'b0, 8'h00, 1'b0, 1'b0);
    emit(ispcs_pkg::OUT_TX, b1, 1'b0, 8'h00, 1'b0, 1'b0);
    emit(ispcs_pkg::OUT_TX, b2, 1'b0, 8'h00, 1'b0, 1'b0);
    emit(ispcs_pkg::OUT_TX, b3, 1'b1, 8'h00, 1'b0, 1'b1);
    seq_phase = ispcs_pkg::PH_REPLY;
  endtask

  task automatic emit_done(input logic [7:0] rv, input logic bz);
    emit(ispcs_pkg::OUT_DONE, 8'h00, 1'b0, rv, bz, 1'b1);
    seq_phase = ispcs_pkg::PH_IDLE;
    readback  = 1'b0;
  endtask

  // Flash read of the held byte address: bit 0 picks the high or low byte
  task automatic emit_flash_read();
    logic [15:0] w;
    w = held_addr >> 1;
    emit_frame(ispcs_pkg::CMD_READ_FLASH | {4'b0, held_addr[0], 3'b0},
               w[15:8], w[7:0], 8'h00);
  endtask

  task automatic next_readback();
    if (tries_left == 0) begin
      emit_done(8'h00, 1'b0);
    end else begin
      tries_left--;
      readback = 1'b1;
      if (cur_op == ispcs_pkg::OP_WRITE_EEPROM) begin
        emit_frame(ispcs_pkg::CMD_READ_EEPROM, held_addr[15:8], held_addr[7:0], 8'h00);
      end else begin
        emit_flash_read();
      end
    end
  endtask

  task automatic after_wait();
    if (readback) begin
      next_readback();
    end else begin
      emit_done(8'h00, 1'b0);
    end
  endtask

  // A zero wait runs the follow-up step within the same word
  task automatic start_wait(input logic [15:0] ticks);
    wait_left = ticks;
    if (wait_left == 0) begin
      after_wait();
    end else begin
      seq_phase = ispcs_pkg::PH_WAIT;
    end
  endtask

  task automatic predict_word(input logic [1:0] kind, input logic [2:0] op,
                              input logic [15:0] addr, input logic [7:0] val,
                              input logic poll, input logic [7:0] reply_b);
    logic [15:0] w;
    logic [7:0]  sel;
    w   = addr >> 1;
    sel = {4'b0, addr[0], 3'b0};
    case (kind)
      ispcs_pkg::KIND_REQ: begin
        // drop requests during an operation and unknown ops
        if (seq_phase == ispcs_pkg::PH_IDLE && op <= ispcs_pkg::OP_BUSY) begin
          cur_op    = op;
          held_addr = addr;
          held_val  = val;
          held_poll = poll;
          readback  = 1'b0;
          case (op)
            ispcs_pkg::OP_READ_FLASH:
              emit_flash_read();
            ispcs_pkg::OP_READ_EEPROM:
              emit_frame(ispcs_pkg::CMD_READ_EEPROM, addr[15:8], addr[7:0], 8'h00);
            ispcs_pkg::OP_WRITE_EEPROM:
              emit_frame(ispcs_pkg::CMD_WRITE_EEPROM, addr[15:8], addr[7:0], val);
            ispcs_pkg::OP_LOAD_FLASH:
              emit_frame(ispcs_pkg::CMD_LOAD_FLASH | sel, w[15:8], w[7:0], val);
            ispcs_pkg::OP_COMMIT_PAGE:
              emit_frame(ispcs_pkg::CMD_COMMIT_PAGE, w[15:8], w[7:0], 8'h00);
            default:
              emit_frame(ispcs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00);
          endcase
        end
      end
      ispcs_pkg::KIND_REPLY: begin
        if (seq_phase == ispcs_pkg::PH_REPLY) begin
          case (cur_op)
            ispcs_pkg::OP_READ_FLASH, ispcs_pkg::OP_READ_EEPROM: emit_done(reply_b, 1'b0);
            ispcs_pkg::OP_BUSY: emit_done(8'h00, reply_b[0]);
            ispcs_pkg::OP_WRITE_EEPROM: begin
              if (readback) begin
                if (reply_b == held_val) emit_done(8'h00, 1'b0);
                else start_wait(settings.eeprom_poll_wait);
              end else if (held_val == ispcs_pkg::ERASED_BYTE) begin
                start_wait(settings.eeprom_full_wait);
              end else begin
                tries_left = settings.eeprom_max_checks;
                readback   = 1'b1;
                next_readback();
              end
            end
            ispcs_pkg::OP_LOAD_FLASH: begin
              if (readback) begin
                if (reply_b != ispcs_pkg::ERASED_BYTE) emit_done(8'h00, 1'b0);
                else start_wait(settings.flash_poll_wait);
              end else if (!held_poll) begin
                emit_done(8'h00, 1'b0);
              end else if (held_val == ispcs_pkg::ERASED_BYTE) begin
                start_wait(settings.flash_full_wait);
              end else begin
                tries_left = settings.flash_max_checks;
                readback   = 1'b1;
                next_readback();
              end
            end
            ispcs_pkg::OP_COMMIT_PAGE: begin
              if (readback) begin
                if (reply_b != ispcs_pkg::ERASED_BYTE) emit_done(8'h00, 1'b0);
                else start_wait(settings.page_poll_wait);
              end else begin
                tries_left = settings.page_poll_tries;
                readback   = 1'b1;
                next_readback();
              end
            end
            default: emit_done(8'h00, 1'b0);
          endcase
        end
      end
      ispcs_pkg::KIND_TICK: begin
        if (seq_phase == ispcs_pkg::PH_WAIT) begin
          if (wait_left > 0) wait_left--;
          if (wait_left == 0) after_wait();
        end
      end
      default: ;  // unknown kind: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving: inputs change on the falling edge, handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then update the model
  task automatic send_word(input logic [1:0] kind, input logic [2:0] op,
                           input logic [15:0] addr, input logic [7:0] val,
                           input logic poll, input logic [7:0] reply_b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, reply_b, poll, val, addr, op};
    do @(posedge clk); while (!in_tready);
    predict_word(kind, op, addr, val, poll, reply_b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic request(input logic [2:0] op, input logic [15:0] addr,
                         input logic [7:0] val, input logic poll);
    send_word(ispcs_pkg::KIND_REQ, op, addr, val, poll, 8'($urandom_range(255)));
  endtask

  // Fields other than the reply byte are don't-care here; randomize them
  task automatic reply(input logic [7:0] b);
    send_word(ispcs_pkg::KIND_REPLY, 3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)),
              8'($urandom_range(255)), 1'($urandom_range(1)), b);
  endtask

  task automatic tick();
    send_word(ispcs_pkg::KIND_TICK, 3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // Drive the running operation to completion: answer frames, tick through waits,
  // and sprinkle in stray words of any kind
  task automatic complete_op(input int pass_pct, input int noise_pct);
    logic [7:0] rb;
    while (seq_phase != ispcs_pkg::PH_IDLE) begin
      rb = 8'($urandom_range(255));
      if ($urandom_range(99) < noise_pct) begin
        send_word(2'($urandom_range(3)), 3'($urandom_range(7)),
                  16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), rb);
      end else if (seq_phase == ispcs_pkg::PH_WAIT) begin
        tick();
      end else begin
        if (readback) begin
          if ($urandom_range(99) < pass_pct) begin
            if (cur_op == ispcs_pkg::OP_WRITE_EEPROM) rb = held_val;
            else if (rb == ispcs_pkg::ERASED_BYTE) rb = 8'h00;
          end else begin
            rb = (cur_op == ispcs_pkg::OP_WRITE_EEPROM) ? ~held_val : ispcs_pkg::ERASED_BYTE;
          end
        end
        reply(rb);
      end
    end
  endtask

  // Drop valid, wait for every expected word, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the block idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      ispcs_pkg::REG_EEPROM_FULL_WAIT:  settings.eeprom_full_wait  = data;
      ispcs_pkg::REG_EEPROM_MAX_CHECKS: settings.eeprom_max_checks = data[7:0];
      ispcs_pkg::REG_EEPROM_POLL_WAIT:  settings.eeprom_poll_wait  = data;
      ispcs_pkg::REG_FLASH_FULL_WAIT:   settings.flash_full_wait   = data;
      ispcs_pkg::REG_FLASH_MAX_CHECKS:  settings.flash_max_checks  = data[7:0];
      ispcs_pkg::REG_FLASH_POLL_WAIT:   settings.flash_poll_wait   = data;
      ispcs_pkg::REG_PAGE_POLL_TRIES:   settings.page_poll_tries   = data[7:0];
      default:                          settings.page_poll_wait    = data;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] ee_full, input logic [7:0] ee_tries,
                               input logic [15:0] ee_wait, input logic [15:0] fl_full,
                               input logic [7:0] fl_tries, input logic [15:0] fl_wait,
                               input logic [7:0] pg_tries, input logic [15:0] pg_wait);
    write_reg(ispcs_pkg::REG_EEPROM_FULL_WAIT, ee_full);
    write_reg(ispcs_pkg::REG_EEPROM_MAX_CHECKS, {8'h00, ee_tries});
    write_reg(ispcs_pkg::REG_EEPROM_POLL_WAIT, ee_wait);
    write_reg(ispcs_pkg::REG_FLASH_FULL_WAIT, fl_full);
    write_reg(ispcs_pkg::REG_FLASH_MAX_CHECKS, {8'h00, fl_tries});
    write_reg(ispcs_pkg::REG_FLASH_POLL_WAIT, fl_wait);
    write_reg(ispcs_pkg::REG_PAGE_POLL_TRIES, {8'h00, pg_tries});
    write_reg(ispcs_pkg::REG_PAGE_POLL_WAIT, pg_wait);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        oldest = expected_words.pop_front();
        check_field("out_kind", 8'(oldest.kind), 8'(out_tuser[0]));
        check_field("tx_byte", oldest.tx_byte, out_tdata[7:0]);
        check_field("frame_end", 8'(oldest.frame_end), 8'(out_tuser[1]));
        check_field("read_value", oldest.read_value, out_tdata[15:8]);
        check_field("busy_bit", 8'(oldest.busy_bit), 8'(out_tdata[16]));
        check_field("last", 8'(oldest.tlast), 8'(out_tlast));
        words_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words still expected",
               cycle_count, expected_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reads at the address extremes, busy checks, and the default try limit
  task automatic test_reads_and_busy();
    request(ispcs_pkg::OP_READ_FLASH, 16'h0000, 8'h00, 1'b0);
    reply(8'h00);
    request(ispcs_pkg::OP_READ_FLASH, 16'hFFFF, 8'hFF, 1'b1);   // odd address: high byte
    reply(8'hFF);
    request(ispcs_pkg::OP_READ_EEPROM, 16'hFFFF, 8'h00, 1'b0);
    reply(8'hA5);
    request(ispcs_pkg::OP_READ_EEPROM, 16'h0000, 8'hFF, 1'b1);
    reply(8'h5A);
    request(ispcs_pkg::OP_BUSY, 16'h8001, 8'h00, 1'b0);
    reply(8'h01);
    request(ispcs_pkg::OP_BUSY, 16'h7FFE, 8'hFF, 1'b1);
    reply(8'hFE);
    // polled write with the reset-time try limit; the first readback matches
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'h1234, 8'h3C, 1'b0);
    reply(8'h00);
    reply(8'h3C);
    settle();
  endtask

  // Words the block must drop without a result, around one flash read
  task automatic test_ignored_words();
    tick();                                        // tick while idle
    reply(8'h77);                                  // reply while idle
    request(3'd6, 16'h00FF, 8'h12, 1'b0);          // unknown ops
    request(3'd7, 16'hFF00, 8'h34, 1'b1);
    send_word(2'd3, ispcs_pkg::OP_READ_FLASH, 16'h0001, 8'h00, 1'b0, 8'h00);  // unknown kind
    request(ispcs_pkg::OP_READ_FLASH, 16'h0001, 8'h00, 1'b0);
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'h0002, 8'h55, 1'b1);   // request during an op
    tick();                                        // tick while awaiting a reply
    send_word(2'd3, ispcs_pkg::OP_BUSY, 16'hFFFF, 8'hFF, 1'b1, 8'hFF);
    reply(8'h3C);
    settle();
  endtask

  // Readback retries, failed last try, zero wait, zero tries, unpolled load
  task automatic test_write_polling();
    load_settings(16'd3, 8'd2, 16'd2, 16'd2, 8'd1, 16'd0, 8'd0, 16'd1);
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'hFFFF, 8'h5A, 1'b0);
    reply(8'h00);
    reply(8'h00);     // first readback misses
    tick();
    tick();
    reply(8'h11);     // last readback misses, the wait still runs out
    tick();
    tick();
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'h0000, ispcs_pkg::ERASED_BYTE, 1'b1);
    complete_op(100, 0);
    request(ispcs_pkg::OP_LOAD_FLASH, 16'h2468, 8'h42, 1'b0);
    reply(8'hFF);
    request(ispcs_pkg::OP_LOAD_FLASH, 16'h1357, 8'h00, 1'b1);
    reply(8'h00);
    reply(ispcs_pkg::ERASED_BYTE);   // zero poll wait: done in the same word
    request(ispcs_pkg::OP_LOAD_FLASH, 16'hFFFE, ispcs_pkg::ERASED_BYTE, 1'b1);
    complete_op(100, 0);
    request(ispcs_pkg::OP_COMMIT_PAGE, 16'hABCD, 8'h00, 1'b0);
    reply(8'h00);         // zero tries: done on the commit reply
    settle();
  endtask

  // Largest and smallest register values
  task automatic test_setting_extremes();
    load_settings(16'hFFFF, 8'd0, 16'd0, 16'd0, 8'd0, 16'hFFFF, 8'd255, 16'd0);
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'h4322, 8'h12, 1'b0);
    reply(8'h00);         // zero tries: done on the write reply
    request(ispcs_pkg::OP_LOAD_FLASH, 16'h0101, ispcs_pkg::ERASED_BYTE, 1'b1);
    reply(8'h00);         // zero full wait: done at once
    request(ispcs_pkg::OP_LOAD_FLASH, 16'h0102, 8'h34, 1'b1);
    reply(8'h00);
    request(ispcs_pkg::OP_COMMIT_PAGE, 16'hFFFF, 8'h00, 1'b0);
    reply(8'h00);
    reply(ispcs_pkg::ERASED_BYTE);   // miss with zero wait: next readback at once
    reply(8'h00);
    settle();
    load_settings(16'd0, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 16'd0, 8'd0, 16'hFFFF);
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'h0F0F, ispcs_pkg::ERASED_BYTE, 1'b0);
    reply(8'h00);
    request(ispcs_pkg::OP_WRITE_EEPROM, 16'hF0F0, 8'h00, 1'b0);
    reply(8'h00);
    reply(8'h00);
    request(ispcs_pkg::OP_LOAD_FLASH, 16'h8000, 8'h80, 1'b1);
    reply(8'h00);
    reply(8'h7F);
    request(ispcs_pkg::OP_COMMIT_PAGE, 16'h0000, 8'h00, 1'b1);
    reply(8'h00);
    settle();
  endtask

  // Hold the result side off while words keep coming, so the job queue fills up
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    repeat (10) begin
      request($urandom_range(1) ? ispcs_pkg::OP_READ_EEPROM : ispcs_pkg::OP_BUSY,
              16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
      reply(8'($urandom_range(255)));
    end
    settle();
  endtask

  // Mostly well-formed operations with random content, some stray and broken words
  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int count);
    int stop_at;
    logic [2:0] op;
    logic [7:0] val;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_settings(16'($urandom_range(6)), 8'($urandom_range(4)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 8'($urandom_range(4)), 16'($urandom_range(6)),
                  8'($urandom_range(4)), 16'($urandom_range(6)));
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      op  = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                      : 3'($urandom_range(ispcs_pkg::OP_BUSY));
      val = ($urandom_range(3) == 0) ? ispcs_pkg::ERASED_BYTE : 8'($urandom_range(255));
      request(op, 16'($urandom_range(16'hFFFF)), val, 1'($urandom_range(1)));
      complete_op(50, 8);
    end
    settle();
  endtask

  initial begin
    // model starts from the reset values of the block
    settings.eeprom_full_wait  = 16'd1000;
    settings.eeprom_max_checks = 8'd10;
    settings.eeprom_poll_wait  = 16'd100;
    settings.flash_full_wait   = 16'd1000;
    settings.flash_max_checks  = 8'd10;
    settings.flash_poll_wait   = 16'd100;
    settings.page_poll_tries   = 8'd10;
    settings.page_poll_wait    = 16'd100;
    seq_phase  = ispcs_pkg::PH_IDLE;
    cur_op     = '0;
    held_addr  = '0;
    held_val   = '0;
    held_poll  = 1'b0;
    tries_left = '0;
    wait_left  = '0;
    readback   = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reads_and_busy();
    test_ignored_words();
    test_write_polling();
    test_setting_extremes();
    test_output_hold_off();
    test_random_mix(0, 0, 34);
    test_random_mix(71, 0, 34);
    test_random_mix(0, 71, 34);
    test_random_mix(23, 23, 34);

    $display("Run covered %0d input words and %0d checked result words, %0d register writes.",
             words_sent, words_checked, reg_writes);
    $display("Directed reads, ignored words, polling and extreme settings, one output hold-off,");
    $display("then random operations under four sender and receiver idle mixes.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ispcs_pkg.sv
design/ispcs_front.sv
design/ispcs_queue.sv
design/ispcs_back.sv
design/isp_programming_command_sequencer_unit.sv
tb/testbench.sv
